// ===== design/buddy_page_allocator_core_macros.svh =====
// assertion macros for the buddy page allocator
`ifndef BUDDY_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define BUDDY_PAGE_ALLOCATOR_CORE_MACROS_SVH
`define BPA_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define BPA_ASSERT_NXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// ===== design/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// types and constants shared by the buddy page allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;
  localparam int ORDERS = 10;
  localparam int MAP_WORDS = 32;
  localparam int WORD_BITS = 16;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_BLOCK = 2'd1;
  localparam logic [1:0] ST_OVERSIZE = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SIZE, S_SCAN_RD, S_SCAN_CHK, S_SPLIT_RD, S_SPLIT_WR,
    S_FREE_RD, S_FREE_CHK, S_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== design/buddy_page_allocator_core.sv =====
// ----------------------------------------------------------------------------
// buddy_page_allocator_core
// binary buddy allocator, one free bitmap per order held in one ram
// ----------------------------------------------------------------------------
// operation: allocate scans each map word of an order in turn (read, check)
// over the orders, then splits one order per read/write state pair; free merges
// one order per read/check pair inside a map word, and across map words also
// passes the split read/write states; one item at a time
// reset: a clearing pass over every map word, stall held high meanwhile
`timescale 1ns / 1ps
`default_nettype none
`include "buddy_page_allocator_core_macros.svh"
module buddy_page_allocator_core
  import bpa_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       mode,
  input  wire logic [9:0] page_count,
  input  wire logic [8:0] page_index,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [8:0]      block_start,
  output logic [1:0]      status
);
  localparam int DEPTH = ORDERS * MAP_WORDS;
  localparam int AW = $clog2(DEPTH);
  localparam int OW = $clog2(ORDERS + 1);
  localparam int WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW = $clog2(WORD_BITS);
  localparam int PAGES = MAP_WORDS * WORD_BITS;
  localparam int PW = $clog2(PAGES) + 1;

  state_t state, state_next;
  logic [OW-1:0] ord, ord_next, need, need_next;
  logic [WW:0] word, word_next;
  logic [PW-1:0] page, page_next;
  logic [AW:0] clr, clr_next;
  logic md, md_next, buddy_hit, buddy_hit_next;
  logic [9:0] cnt, cnt_next;
  logic [8:0] bs, bs_next;
  logic [1:0] st, st_next;

  logic we;
  logic [AW-1:0] addr;
  logic [WORD_BITS-1:0] wdata, rdata;

  bpa_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic [PW-1:0] tgt, blk;
  logic tgt_in;
  logic [BW-1:0] low_bit;
  logic word_nz;

  function automatic logic [AW-1:0] map_addr(logic [OW-1:0] o, logic [PW-1:0] p);
    logic [AW+OW:0] a;
    a = (AW+OW+1)'(o) * (AW+OW+1)'(MAP_WORDS) + (AW+OW+1)'(p / WORD_BITS);
    return a[AW-1:0];
  endfunction

  always_comb begin
    low_bit = '0;
    word_nz = |rdata;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (rdata[b]) begin
        low_bit = BW'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
    end else begin
      state <= state_next;
      clr <= clr_next;
    end
    ord <= ord_next; need <= need_next; word <= word_next; page <= page_next;
    md <= md_next; cnt <= cnt_next; bs <= bs_next; st <= st_next;
    buddy_hit <= buddy_hit_next;
  end

  always_comb begin
    state_next = state;
    ord_next = ord; need_next = need; word_next = word; page_next = page;
    md_next = md; cnt_next = cnt; bs_next = bs; st_next = st;
    buddy_hit_next = buddy_hit; clr_next = clr;
    we = 1'b0; addr = '0; wdata = '0;
    in_stall = 1'b1; out_valid = 1'b0;
    tgt = '0; tgt_in = 1'b0;
    blk = PW'(1) << ord;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        addr = clr[AW-1:0];
        wdata = (clr[AW-1:0] == AW'((ORDERS - 1) * MAP_WORDS)) ? WORD_BITS'(1) : '0;
        clr_next = clr + 1'b1;
        if (clr == (AW+1)'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          md_next = mode; cnt_next = page_count; page_next = PW'(page_index);
          ord_next = '0; bs_next = '0; st_next = ST_OK; word_next = '0;
          buddy_hit_next = 1'b0;
          state_next = S_SIZE;
        end
      end
      S_SIZE: begin
        if (cnt <= 10'(blk) || (cnt == 10'd0)) begin
          need_next = ord;
          word_next = '0;
          if (md == MODE_ALLOC) begin
            state_next = S_SCAN_RD;
          end else begin
            page_next = page & ~(blk - 1'b1);
            state_next = S_FREE_RD;
          end
        end else if (ord == OW'(ORDERS - 1) || blk[PW-1:0] >= PW'(512)) begin
          st_next = ST_OVERSIZE;
          state_next = S_OUT;
        end else begin
          ord_next = ord + 1'b1;
        end
      end
      S_SCAN_RD: begin
        addr = map_addr(ord, PW'(word) * PW'(WORD_BITS));
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (word_nz) begin
          page_next = PW'(word) * PW'(WORD_BITS) + PW'(low_bit);
          bs_next = 9'(PW'(word) * PW'(WORD_BITS) + PW'(low_bit));
          addr = map_addr(ord, PW'(word) * PW'(WORD_BITS));
          we = 1'b1;
          wdata = rdata & ~(WORD_BITS'(1) << low_bit);
          state_next = (ord == need) ? S_OUT : S_SPLIT_RD;
          ord_next = ord - ((ord == need) ? 1'b0 : 1'b1);
        end else if (word == (WW+1)'(MAP_WORDS - 1)) begin
          word_next = '0;
          if (ord == OW'(ORDERS - 1)) begin
            st_next = ST_NO_BLOCK;
            state_next = S_OUT;
          end else begin
            ord_next = ord + 1'b1;
            state_next = S_SCAN_RD;
          end
        end else begin
          word_next = word + 1'b1;
          state_next = S_SCAN_RD;
        end
      end
      S_SPLIT_RD: begin
        tgt = page + blk;
        addr = map_addr(ord, tgt);
        state_next = S_SPLIT_WR;
      end
      S_SPLIT_WR: begin
        tgt = page + blk;
        tgt_in = tgt < PW'(PAGES);
        addr = map_addr(ord, tgt);
        we = tgt_in;
        wdata = rdata | (WORD_BITS'(1) << tgt[BW-1:0]);
        if (ord == need) begin
          state_next = S_OUT;
        end else begin
          ord_next = ord - 1'b1;
          state_next = S_SPLIT_RD;
        end
      end
      S_FREE_RD: begin
        addr = map_addr(ord, page);
        state_next = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        tgt = page ^ blk;
        tgt_in = (page < PW'(PAGES)) && (tgt < PW'(PAGES)) && (ord != OW'(ORDERS - 1));
        addr = map_addr(ord, page);
        buddy_hit_next = 1'b0;
        if (buddy_hit) begin
          we = 1'b1;
          wdata = rdata & ~(WORD_BITS'(1) << page[BW-1:0]);
          page_next = page & ~blk;
          ord_next = ord + 1'b1;
          state_next = S_FREE_RD;
        end else if (tgt_in && rdata[tgt[BW-1:0]] && (page / WORD_BITS) == (tgt / WORD_BITS)) begin
          we = 1'b1;
          wdata = rdata & ~(WORD_BITS'(1) << page[BW-1:0]) & ~(WORD_BITS'(1) << tgt[BW-1:0]);
          page_next = page & ~blk;
          ord_next = ord + 1'b1;
          state_next = S_FREE_RD;
        end else begin
          we = page < PW'(PAGES);
          wdata = rdata | (WORD_BITS'(1) << page[BW-1:0]);
          state_next = (tgt_in && (page / WORD_BITS) != (tgt / WORD_BITS)) ? S_SPLIT_RD
                       : S_OUT;
          if (tgt_in && (page / WORD_BITS) != (tgt / WORD_BITS)) begin
            md_next = MODE_FREE;
          end
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_SPLIT_RD && md == MODE_FREE) begin
      tgt = page ^ blk;
      addr = map_addr(ord, tgt);
      state_next = S_SPLIT_WR;
    end
    if (state == S_SPLIT_WR && md == MODE_FREE) begin
      tgt = page ^ blk;
      addr = map_addr(ord, tgt);
      we = 1'b0;
      wdata = '0;
      ord_next = ord;
      if (rdata[tgt[BW-1:0]]) begin
        we = 1'b1;
        wdata = rdata & ~(WORD_BITS'(1) << tgt[BW-1:0]);
        buddy_hit_next = 1'b1;
        state_next = S_FREE_RD;
      end else begin
        state_next = S_OUT;
      end
    end
  end

  assign block_start = bs;
  assign status = st;

  `BPA_ASSERT_IMP(a_out_only_in_out, clk, rst, out_valid, state == S_OUT, "out_valid outside output state")
  `BPA_ASSERT_IMP(a_stall_when_busy, clk, rst, state != S_IDLE, in_stall, "ready while busy")
  `BPA_ASSERT_IMP(a_fail_zero, clk, rst, out_valid && st != ST_OK, bs == '0, "nonzero start on failure")
  `BPA_ASSERT_NXT(a_accept_leaves_idle, clk, rst, in_valid && !in_stall, state == S_SIZE, "accept did not start")
endmodule
`default_nettype wire

// ===== design/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// bpa_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 320
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire
